[hdl/assert_macros.svh]
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_SAME_CYCLE(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ASSERT_NEXT_CYCLE(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_SAME_CYCLE(label, clk, rstn, ante, cons)

`define ASSERT_NEXT_CYCLE(label, clk, rstn, ante, cons)

`endif

`endif

[hdl/sogi_qsg_pkg.sv]
package sogi_qsg_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int COEF_FRAC_BITS = 30;
    localparam int COEF_BITS      = 32;
    localparam int HIST_BITS      = 40;
    localparam int OUT_BITS       = 18;
    localparam int Q16_BITS       = 17;
    localparam int NUM_BITS       = Q16_BITS + 2;
    localparam int HIST_SPLIT     = 20;
    localparam int CFG_IDX_BITS   = 2;

    localparam int Q_UP = (SAMPLE_BITS <= Q16_BITS) ? Q16_BITS - SAMPLE_BITS : 0;
    localparam int Q_DN = (SAMPLE_BITS > Q16_BITS) ? SAMPLE_BITS - Q16_BITS : 0;

    typedef logic signed [COEF_BITS-1:0]   coef_t;
    typedef logic signed [HIST_BITS-1:0]   hist_t;
    typedef logic signed [OUT_BITS-1:0]    out_t;
    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [Q16_BITS-1:0]    q16_t;
    typedef logic signed [NUM_BITS-1:0]    num_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_IN_PHASE_GAIN = 2'd0,
        CFG_POLE_ONE      = 2'd1,
        CFG_POLE_TWO      = 2'd2,
        CFG_QUAD_GAIN     = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        coef_t in_phase_gain;
        coef_t pole_one;
        coef_t pole_two;
        coef_t quad_gain;
    } coef_set_t;

    localparam hist_t OUT_MAX_H = hist_t'((64'sd1 <<< (OUT_BITS - 1)) - 64'sd1);
    localparam hist_t OUT_MIN_H = hist_t'(-(64'sd1 <<< (OUT_BITS - 1)));

    // sample to 16 fraction bits, floor on the way down
    function automatic q16_t to_q16(input sample_t x);
        logic signed [SAMPLE_BITS+Q_UP-1:0] w;
        begin
            w = (SAMPLE_BITS + Q_UP)'(x);
            w = w <<< Q_UP;
            return Q16_BITS'(w >>> Q_DN);
        end
    endfunction

    function automatic out_t sat_out(input hist_t v);
        begin
            if (v > OUT_MAX_H) begin
                return out_t'(OUT_MAX_H);
            end else if (v < OUT_MIN_H) begin
                return out_t'(OUT_MIN_H);
            end
            return out_t'(v);
        end
    endfunction

endpackage

[hdl/sogi_qsg_cfg.sv]
module sogi_qsg_cfg
    import sogi_qsg_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [COEF_BITS-1:0]    cfg_wr_data,
    output coef_set_t               coef
);

    coef_set_t coef_reg;
    coef_set_t coef_next;

    always_comb begin
        coef_next = coef_reg;
        if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_IN_PHASE_GAIN: coef_next.in_phase_gain = coef_t'(cfg_wr_data);
                CFG_POLE_ONE:      coef_next.pole_one      = coef_t'(cfg_wr_data);
                CFG_POLE_TWO:      coef_next.pole_two      = coef_t'(cfg_wr_data);
                CFG_QUAD_GAIN:     coef_next.quad_gain     = coef_t'(cfg_wr_data);
                default:           coef_next = coef_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg <= '0;
        end else begin
            coef_reg <= coef_next;
        end
    end

    assign coef = coef_reg;

endmodule

[hdl/sogi_qsg_branch.sv]
module sogi_qsg_branch
    import sogi_qsg_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  step,
    input  coef_t pole_one,
    input  coef_t pole_two,
    input  coef_t gain,
    input  num_t  numerator,
    output hist_t hist_next,
    output hist_t hist_one
);

    localparam int PROD_BITS = COEF_BITS + HIST_BITS;
    localparam int TERM_BITS = PROD_BITS - COEF_FRAC_BITS;
    localparam int NPROD_BITS = COEF_BITS + NUM_BITS;
    localparam int SUM_BITS  = TERM_BITS + 2;

    typedef logic signed [TERM_BITS-1:0] term_t;
    typedef logic signed [SUM_BITS-1:0]  sum_t;

    localparam sum_t HIST_MAX_S = sum_t'((64'sd1 <<< (HIST_BITS - 1)) - 64'sd1);
    localparam sum_t HIST_MIN_S = sum_t'(-(64'sd1 <<< (HIST_BITS - 1)));

    // coef * history as two narrow partial products, rounded to 16 fraction bits
    function automatic term_t mul_hist(input coef_t c, input hist_t h);
        logic signed [HIST_BITS-HIST_SPLIT-1:0]           hi;
        logic signed [HIST_SPLIT:0]                       lo;
        logic signed [COEF_BITS+HIST_BITS-HIST_SPLIT-1:0] ph;
        logic signed [COEF_BITS+HIST_SPLIT:0]             pl;
        logic signed [PROD_BITS-1:0]                      p;
        begin
            hi = h[HIST_BITS-1:HIST_SPLIT];
            lo = $signed({1'b0, h[HIST_SPLIT-1:0]});
            ph = c * hi;
            pl = c * lo;
            p  = (PROD_BITS'(ph) <<< HIST_SPLIT) + PROD_BITS'(pl);
            p  = p + (PROD_BITS'(1) << (COEF_FRAC_BITS - 1));
            return TERM_BITS'(p >>> COEF_FRAC_BITS);
        end
    endfunction

    function automatic term_t mul_num(input coef_t c, input num_t n);
        logic signed [NPROD_BITS-1:0] p;
        begin
            p = c * n;
            p = p + (NPROD_BITS'(1) << (COEF_FRAC_BITS - 1));
            return TERM_BITS'(p >>> COEF_FRAC_BITS);
        end
    endfunction

    hist_t h1_reg;
    hist_t h2_reg;
    sum_t  sum;

    always_comb begin
        sum = SUM_BITS'(mul_hist(pole_one, h1_reg))
            + SUM_BITS'(mul_hist(pole_two, h2_reg))
            + SUM_BITS'(mul_num(gain, numerator));
        if (sum > HIST_MAX_S) begin
            hist_next = hist_t'(HIST_MAX_S);
        end else if (sum < HIST_MIN_S) begin
            hist_next = hist_t'(HIST_MIN_S);
        end else begin
            hist_next = hist_t'(sum);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            h1_reg <= '0;
            h2_reg <= '0;
        end else if (step) begin
            h2_reg <= h1_reg;
            h1_reg <= hist_next;
        end
    end

    assign hist_one = h1_reg;

endmodule

[hdl/sogi_quadrature_generator.sv]
// Channel  | Ports                           | Carries
// ---------+---------------------------------+------------------------------
// input    | s_valid s_ready s_sample        | one Q1.15 sample
// result   | m_valid m_ready m_in_phase      | doubled in-phase and
//          | m_quadrature                    | quadrature values, Q2.16
// config   | cfg_wr_en cfg_index cfg_wr_data | one coefficient write
//
// One transaction per cycle sustained unless m_ready stalls; the input register
// feeds the result register. The limit is the history feedback: for both
// branches the multiply-round-add-saturate is combinational between those registers.
// Synchronous active-low reset clears coefficients, delay line and history.
// A stalled result holds the input register; input is taken while the result drains.
`include "assert_macros.svh"

module sogi_quadrature_generator
    import sogi_qsg_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [SAMPLE_BITS-1:0]  s_sample,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [OUT_BITS-1:0]     m_in_phase,
    output logic [OUT_BITS-1:0]     m_quadrature,
    input  logic                    cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [COEF_BITS-1:0]    cfg_wr_data
);

    coef_set_t coef;
    logic      in_valid_reg;
    sample_t   sample_reg;
    sample_t   x1_reg;
    sample_t   x2_reg;
    logic      m_valid_reg;
    out_t      in_phase_reg;
    out_t      quad_reg;
    logic      adv;
    q16_t      q0;
    q16_t      q1;
    q16_t      q2;
    num_t      dir_num;
    num_t      quad_num;
    hist_t     dir_next;
    hist_t     dir_hist_one;
    hist_t     quad_next;
    hist_t     quad_hist_one;

    sogi_qsg_cfg u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .coef        (coef)
    );

    assign adv     = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || adv;

    assign q0       = to_q16(sample_reg);
    assign q1       = to_q16(x1_reg);
    assign q2       = to_q16(x2_reg);
    assign dir_num  = NUM_BITS'(q0) - NUM_BITS'(q2);
    assign quad_num = NUM_BITS'(q0) + (NUM_BITS'(q1) <<< 1) + NUM_BITS'(q2);

    sogi_qsg_branch u_direct (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (adv),
        .pole_one  (coef.pole_one),
        .pole_two  (coef.pole_two),
        .gain      (coef.in_phase_gain),
        .numerator (dir_num),
        .hist_next (dir_next),
        .hist_one  (dir_hist_one)
    );

    sogi_qsg_branch u_quad (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (adv),
        .pole_one  (coef.pole_one),
        .pole_two  (coef.pole_two),
        .gain      (coef.quad_gain),
        .numerator (quad_num),
        .hist_next (quad_next),
        .hist_one  (quad_hist_one)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            x1_reg       <= '0;
            x2_reg       <= '0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (adv) begin
                in_valid_reg <= 1'b0;
            end
            if (adv) begin
                m_valid_reg <= 1'b1;
                x2_reg      <= x1_reg;
                x1_reg      <= sample_reg;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            sample_reg <= sample_t'(s_sample);
        end
        if (adv) begin
            in_phase_reg <= sat_out(dir_next);
            quad_reg     <= sat_out(quad_next);
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_in_phase   = in_phase_reg;
    assign m_quadrature = quad_reg;

    `ASSERT_NEXT_CYCLE(a_adv_gives_result, aclk, aresetn, adv, m_valid)
    `ASSERT_SAME_CYCLE(a_stall_cause, aclk, aresetn, !s_ready, in_valid_reg && m_valid_reg && !m_ready)
    `ASSERT_NEXT_CYCLE(a_in_phase_from_hist, aclk, aresetn, adv, m_in_phase == sat_out(dir_hist_one))
    `ASSERT_NEXT_CYCLE(a_quad_from_hist, aclk, aresetn, adv, m_quadrature == sat_out(quad_hist_one))

endmodule
